// ----- src/strs_pkg.sv -----
// Shared types and constants for the segment-tree range-sum block.
// Used by the channel interfaces and by the top level; depends on nothing.
`default_nettype none

package strs_pkg;

  // Field widths of the input and result beats.
  localparam int unsigned POS_W   = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BOUND_W = 11;
  localparam int unsigned SUM_W   = 42;

  typedef logic        [POS_W-1:0]   pos_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic        [BOUND_W-1:0] bound_t;
  typedef logic        [SUM_W-1:0]   sum_t;

  // Item kinds carried in the mode field.
  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage : strs_pkg

`default_nettype wire

// ----- src/strs_in_if.sv -----
// Input channel of the range-sum block: valid/ready plus the item fields.
// Depends on strs_pkg for the field types.
`default_nettype none

interface strs_in_if;
  logic            valid;
  logic            ready;
  logic            mode;
  strs_pkg::pos_t   position;
  strs_pkg::value_t value;
  strs_pkg::bound_t range_begin;
  strs_pkg::bound_t range_end;

  modport source (
    output valid, mode, position, value, range_begin, range_end,
    input  ready
  );
  modport sink (
    input  valid, mode, position, value, range_begin, range_end,
    output ready
  );
endinterface : strs_in_if

`default_nettype wire

// ----- src/strs_out_if.sv -----
// Result channel of the range-sum block: valid/ready plus the sum field.
// Depends on strs_pkg for the field type.
`default_nettype none

interface strs_out_if;
  logic           valid;
  logic           ready;
  strs_pkg::sum_t sum;

  modport source (
    output valid, sum,
    input  ready
  );
  modport sink (
    input  valid, sum,
    output ready
  );
endinterface : strs_out_if

`default_nettype wire

// ----- src/strs_ram.sv -----
// Generic single-port RAM with a registered read (read-first).
// Standalone; no package needed.
`default_nettype none

module strs_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One access per cycle; the read returns the old contents on a write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule : strs_ram

`default_nettype wire

// ----- src/segment_tree_range_sum.sv -----
// Top level of the bottom-up segment tree with range-sum queries.
// Depends on strs_pkg, strs_in_if, strs_out_if and strs_ram.
`default_nettype none

// The block holds 2*LEAVES node sums of 42 bits in one single-port RAM and
// walks the tree with a small sequencer around one shared 42-bit adder.
// After reset it clears the node RAM, one entry per cycle; in_ch.ready
// stays low until all 2*LEAVES entries (2048 by default) are clear. An
// update (mode 0) does one leaf write, then for each ancestor one sibling
// read and one add-and-write; a position at or above LEAVES is dropped. A
// query (mode 1) walks the tree one level per ST_QTEST step, with one more
// step for every boundary node that is summed, since each costs one RAM
// read through the single port, and a final step that loads the result.
// Bounds above LEAVES are clamped to LEAVES and an empty range returns
// zero. The result waits in an output register, so new items are taken
// while it is still pending; a query can only finish once that register
// is free.
module segment_tree_range_sum #(
  parameter int unsigned LEAVES = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  strs_in_if.sink     in_ch,
  strs_out_if.source  out_ch
);

  import strs_pkg::*;

  localparam int unsigned NODES = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(NODES);
  localparam int unsigned IW    = AW + 1;
  localparam int unsigned CW    = (IW > BOUND_W) ? IW : BOUND_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UWRITE,
    ST_UREAD,
    ST_USUM,
    ST_QTEST,
    ST_QBACC,
    ST_QEACC
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic [IW-1:0]   b_r, b_nxt;
  logic [IW-1:0]   e_r, e_nxt;
  sum_t            acc_r, acc_nxt;
  logic            out_valid_r, out_valid_nxt;
  sum_t            out_sum_r, out_sum_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  sum_t            ram_wdata;
  sum_t            ram_rdata;

  // Shared adder and the helpers around it.
  sum_t            add_sum;
  logic [CW-1:0]   leaves_c;
  logic [CW-1:0]   pos_ext;
  logic [CW-1:0]   rb_ext, re_ext, rb_sat, re_sat;
  logic [IW-1:0]   e_m1;
  logic [IW-1:0]   b_p1;
  logic [AW-1:0]   parent;

  assign add_sum  = acc_r + ram_rdata;
  assign leaves_c = CW'(LEAVES);
  assign pos_ext  = CW'(in_ch.position);
  assign rb_ext   = CW'(in_ch.range_begin);
  assign re_ext   = CW'(in_ch.range_end);
  assign rb_sat   = (rb_ext > leaves_c) ? leaves_c : rb_ext;
  assign re_sat   = (re_ext > leaves_c) ? leaves_c : re_ext;
  assign e_m1     = e_r - IW'(1);
  assign b_p1     = b_r + IW'(1);
  assign parent   = cur_r >> 1;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.sum   = out_sum_r;

  // Node sum store.
  strs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NODES)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer: next state, RAM port and datapath registers.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sum_nxt   = out_sum_r;
    ram_we        = 1'b0;
    ram_addr      = cur_r;
    ram_wdata     = add_sum;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.mode == MODE_QUERY) begin
            acc_nxt   = '0;
            b_nxt     = IW'(rb_sat + leaves_c);
            e_nxt     = IW'(re_sat + leaves_c);
            state_nxt = ST_QTEST;
          end else if (pos_ext < leaves_c) begin
            // Leaf value is sign-extended to the node width.
            acc_nxt   = {{(SUM_W - VALUE_W){in_ch.value[VALUE_W-1]}}, in_ch.value};
            cur_nxt   = AW'(pos_ext + leaves_c);
            state_nxt = ST_UWRITE;
          end
        end
      end

      ST_UWRITE: begin
        ram_we    = 1'b1;
        ram_addr  = cur_r;
        ram_wdata = acc_r;
        state_nxt = ST_UREAD;
      end

      // The just-written child is in acc_r, so only its sibling is read.
      ST_UREAD: begin
        ram_addr  = cur_r ^ AW'(1);
        state_nxt = ST_USUM;
      end

      ST_USUM: begin
        ram_we    = 1'b1;
        ram_addr  = parent;
        ram_wdata = add_sum;
        acc_nxt   = add_sum;
        cur_nxt   = parent;
        state_nxt = (parent == AW'(1)) ? ST_IDLE : ST_UREAD;
      end

      // One tree level of the query walk; both boundaries feed one accumulator.
      ST_QTEST: begin
        if (!(b_r < e_r)) begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_nxt = 1'b1;
            out_sum_nxt   = acc_r;
            state_nxt     = ST_IDLE;
          end
        end else if (b_r[0]) begin
          ram_addr  = b_r[AW-1:0];
          state_nxt = ST_QBACC;
        end else if (e_r[0]) begin
          ram_addr  = e_m1[AW-1:0];
          state_nxt = ST_QEACC;
        end else begin
          b_nxt = b_r >> 1;
          e_nxt = e_r >> 1;
        end
      end

      ST_QBACC: begin
        acc_nxt = add_sum;
        if (e_r[0]) begin
          ram_addr  = e_m1[AW-1:0];
          b_nxt     = b_p1;
          state_nxt = ST_QEACC;
        end else begin
          b_nxt     = b_p1 >> 1;
          e_nxt     = e_r >> 1;
          state_nxt = ST_QTEST;
        end
      end

      ST_QEACC: begin
        acc_nxt   = add_sum;
        b_nxt     = b_r >> 1;
        e_nxt     = e_m1 >> 1;
        state_nxt = ST_QTEST;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r     <= cur_nxt;
    b_r       <= b_nxt;
    e_r       <= e_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
  end

endmodule : segment_tree_range_sum

`default_nettype wire
